>>> rtl/timed_key_press_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timed key press sequencer
// Shared concurrent assertion forms, clocked and gated by reset.
// ----------------------------------------------------------------------------
`ifndef TIMED_KEY_PRESS_SEQUENCER_UNIT_MACROS_SVH
`define TIMED_KEY_PRESS_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication
`define TKPS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TKPS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tkps_pkg.sv
// ----------------------------------------------------------------------------
// tkps_pkg
// Types and codes shared by the key press sequencer front, back and checker.
// ----------------------------------------------------------------------------
package tkps_pkg;

  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_SERVICE = 1'b1;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_GAP     = 2'd2
  } phase_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } bk_state_t;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_SERVICE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0]  modifier;
    logic [7:0]  key;
    logic [15:0] hold;
    logic [15:0] gap;
  } entry_t;

  typedef struct packed {
    cmd_kind_t   kind;
    entry_t      entry;
    logic [31:0] now;
    logic        ready;
    logic        susp;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] modifier;
    logic [7:0] key;
    logic       wake;
    logic       dropped;
    logic [7:0] count;
  } result_t;

endpackage

>>> rtl/tkps_ram.sv
// ----------------------------------------------------------------------------
// tkps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tkps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/tkps_front.sv
// ----------------------------------------------------------------------------
// tkps_front
// Accept command words, classify them and hold them in a short queue.
// ----------------------------------------------------------------------------
module tkps_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic          func,
  input  logic [7:0]    modifier_bits,
  input  logic [7:0]    key_code,
  input  logic [15:0]   hold_ms,
  input  logic [15:0]   gap_ms,
  input  logic [31:0]   now_ms,
  input  logic          link_ready,
  input  logic          host_suspended,
  output logic          q_valid,
  output tkps_pkg::cmd_t q_cmd,
  input  logic          q_pop
);

  tkps_pkg::cmd_t       slots [tkps_pkg::QUEUE_DEPTH];
  logic [tkps_pkg::QPW-1:0] wr_ptr;
  logic [tkps_pkg::QPW-1:0] rd_ptr;
  logic [tkps_pkg::QCW-1:0] fill;
  logic                 push;
  tkps_pkg::cmd_t       cmd_in;

  assign busy    = (fill == tkps_pkg::QCW'(tkps_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill != '0);
  assign q_cmd   = slots[rd_ptr];

  // classify on entry
  always_comb begin
    cmd_in.kind  = (func == tkps_pkg::FUNC_SERVICE) ? tkps_pkg::CMD_SERVICE
                                                    : tkps_pkg::CMD_ENQUEUE;
    cmd_in.entry = '{modifier: modifier_bits, key: key_code,
                     hold: hold_ms, gap: gap_ms};
    cmd_in.now   = now_ms;
    cmd_in.ready = link_ready;
    cmd_in.susp  = host_suspended;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> rtl/tkps_back.sv
// ----------------------------------------------------------------------------
// tkps_back
// Execute queued commands: key FIFO push, and the press/release/gap machine.
// ----------------------------------------------------------------------------
module tkps_back #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  tkps_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              done,
  output tkps_pkg::result_t result
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(FIFO_DEPTH);

  tkps_pkg::bk_state_t state, state_next;
  tkps_pkg::cmd_t      cur;
  tkps_pkg::phase_t    phase, phase_next;
  tkps_pkg::result_t   res_next;
  tkps_pkg::entry_t    head_entry;
  logic [PW-1:0]       head, head_next;
  logic [PW-1:0]       tail, tail_next;
  logic [CW-1:0]       count, count_next;
  logic [31:0]         phase_start, phase_start_next;
  logic [31:0]         elapsed;
  logic [CW+7:0]       count_wide;
  logic                exec;
  logic                wr_en;
  logic [$bits(tkps_pkg::entry_t)-1:0] rd_data;

  tkps_ram #(
    .WIDTH ($bits(tkps_pkg::entry_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (cur.entry),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  assign head_entry = tkps_pkg::entry_t'(rd_data);
  assign elapsed    = cur.now - phase_start;

  always_comb begin
    state_next = state;
    case (state)
      tkps_pkg::BK_IDLE: if (q_valid) state_next = tkps_pkg::BK_EXEC;
      tkps_pkg::BK_EXEC: state_next = tkps_pkg::BK_IDLE;
      default:           state_next = tkps_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == tkps_pkg::BK_IDLE) && q_valid;
    exec  = (state == tkps_pkg::BK_EXEC);
  end

  always_comb begin
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    phase_next       = phase;
    phase_start_next = phase_start;
    wr_en            = 1'b0;
    res_next         = '0;
    if (cur.kind == tkps_pkg::CMD_ENQUEUE) begin
      if (count != FULL) begin
        wr_en      = exec;
        tail_next  = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
        count_next = count + 1'b1;
      end else begin
        res_next.dropped = 1'b1;
      end
    end else begin
      res_next.wake = cur.susp;
      if (cur.ready) begin
        case ((count == '0) ? tkps_pkg::PH_IDLE : phase)
          tkps_pkg::PH_PRESSED: begin
            if (elapsed >= {16'd0, head_entry.hold}) begin
              res_next.action  = tkps_pkg::ACT_RELEASE;
              phase_start_next = cur.now;
              phase_next       = tkps_pkg::PH_GAP;
            end
          end
          tkps_pkg::PH_GAP: begin
            if (elapsed >= {16'd0, head_entry.gap}) begin
              head_next  = (head == LAST_SLOT) ? '0 : head + 1'b1;
              count_next = count - 1'b1;
              phase_next = tkps_pkg::PH_IDLE;
            end
          end
          default: begin
            phase_next = tkps_pkg::PH_IDLE;
            if (count != '0) begin
              res_next.action   = tkps_pkg::ACT_PRESS;
              res_next.modifier = head_entry.modifier;
              res_next.key      = head_entry.key;
              phase_start_next  = cur.now;
              phase_next        = tkps_pkg::PH_PRESSED;
            end
          end
        endcase
      end
    end
    count_wide     = {8'd0, count_next};
    res_next.count = count_wide[7:0];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (exec) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tkps_pkg::BK_IDLE;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      phase       <= tkps_pkg::PH_IDLE;
      phase_start <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
      if (exec) begin
        head        <= head_next;
        tail        <= tail_next;
        count       <= count_next;
        phase       <= phase_next;
        phase_start <= phase_start_next;
      end
    end
  end

endmodule

>>> rtl/timed_key_press_sequencer_unit.sv
// ----------------------------------------------------------------------------
// timed_key_press_sequencer_unit
// Key press FIFO with a timed press / release / gap report sequencer.
// ----------------------------------------------------------------------------
// Issue a command word by raising start while busy is low. A word with func
// low appends a key press (modifier, key, hold and gap times) to the key FIFO
// or flags a drop when the FIFO is full; a word with func high is a service
// poll carrying the millisecond time and link status. Every word yields
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall, so capture it on that cycle. Words wait in a two-entry command queue
// and busy rises only when that queue is full. The back end handles each word
// in an idle state that reads the head entry from the key memory (registered
// read port) and an execute state, and it pops no new word until the last one
// has executed. With the queue empty, an accepted word passes the queue slot,
// the back end's idle and execute states and the result register on its way
// to the ports. The key memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module timed_key_press_sequencer_unit #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [7:0]  modifier_bits,
  input  logic [7:0]  key_code,
  input  logic [15:0] hold_ms,
  input  logic [15:0] gap_ms,
  input  logic [31:0] now_ms,
  input  logic        link_ready,
  input  logic        host_suspended,
  output logic        done,
  output logic [1:0]  action,
  output logic [7:0]  out_modifier,
  output logic [7:0]  out_key,
  output logic        wake_request,
  output logic        enqueue_dropped,
  output logic [7:0]  queued_count
);

  // command queue handoff between the front and back halves
  logic              q_valid;
  logic              q_pop;
  tkps_pkg::cmd_t    q_cmd;
  tkps_pkg::result_t result;

  // front: accept and classify words, hold them until the back end is free
  tkps_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .modifier_bits  (modifier_bits),
    .key_code       (key_code),
    .hold_ms        (hold_ms),
    .gap_ms         (gap_ms),
    .now_ms         (now_ms),
    .link_ready     (link_ready),
    .host_suspended (host_suspended),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop)
  );

  // back: key FIFO, phase machine and the registered result
  tkps_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .done    (done),
    .result  (result)
  );

  // fan the result word out to its ports
  assign action          = result.action;
  assign out_modifier    = result.modifier;
  assign out_key         = result.key;
  assign wake_request    = result.wake;
  assign enqueue_dropped = result.dropped;
  assign queued_count    = result.count;

endmodule

>>> rtl/tkps_checker.sv
// ----------------------------------------------------------------------------
// tkps_checker
// Port-level checks on the sequencer's result words.
// ----------------------------------------------------------------------------
`include "timed_key_press_sequencer_unit_macros.svh"

module tkps_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       done,
  input logic [1:0] action,
  input logic [7:0] out_modifier,
  input logic [7:0] out_key,
  input logic       wake_request,
  input logic       enqueue_dropped
);

  logic not_press;
  logic bytes_zero;
  logic drop_seen;
  logic svc_quiet;

  assign not_press  = done && (action != tkps_pkg::ACT_PRESS);
  assign bytes_zero = (out_modifier == 8'd0) && (out_key == 8'd0);
  assign drop_seen  = done && enqueue_dropped;
  assign svc_quiet  = (action == tkps_pkg::ACT_NONE) && !wake_request;

  // each word passes the back end's idle state before it executes, so results never come back to back
  `TKPS_ASSERT_NXT(a_done_spaced, clk, rst, done, !done, "done in two adjacent cycles")

  // report bytes only travel with a press
  `TKPS_ASSERT_IMP(a_bytes_press_only, clk, rst, not_press, bytes_zero, "bytes without press")

  // a drop comes from an enqueue, which never reports or wakes
  `TKPS_ASSERT_IMP(a_drop_is_enqueue, clk, rst, drop_seen, svc_quiet, "drop with activity")

endmodule

bind timed_key_press_sequencer_unit tkps_port_checks u_tkps_checker (.*);
